// ----- rtl/bbl_pkg.sv -----
// bitmap blit package: shared types and panel constants
// no dependencies; imported by every module of the blit block
`timescale 1ns / 1ps

package bbl_pkg;

   // panel geometry and remap constants
   localparam int unsigned PanelW   = 16;
   localparam int unsigned PanelH   = 18;
   localparam logic [3:0]  MirrorX  = 4'd15;
   localparam logic [4:0]  MirrorY  = 5'd17;
   localparam logic [4:0]  FoldX    = 5'd23;
   localparam logic [4:0]  FoldYLo  = 5'd8;
   localparam logic [4:0]  FoldYHi  = 5'd26;
   localparam int unsigned MaxPix   = 8;
   localparam int unsigned FbDepth  = PanelW * PanelH;

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_DEPTH_MODE   = 3'd0,
      CSR_ORIGIN_X     = 3'd1,
      CSR_ORIGIN_Y     = 3'd2,
      CSR_IMAGE_WIDTH  = 3'd3,
      CSR_IMAGE_HEIGHT = 3'd4,
      CSR_FORE_COLOUR  = 3'd5,
      CSR_BACK_COLOUR  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [7:0] bitmap_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      logic [8:0] fb_index;
      logic [7:0] pixel_value;
      logic       in_panel;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       depth_mode;
      logic [7:0] origin_x;
      logic [7:0] origin_y;
      logic [7:0] image_width;
      logic [7:0] image_height;
      logic [7:0] fore_colour;
      logic [7:0] back_colour;
   } cfg_type;

   // one byte's run of pixels, handed from the cursor unit to the emitter
   typedef struct packed {
      logic       valid;
      logic       depth_mode;
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] bits;
      logic [3:0] count;
   } plan_type;

endpackage

// ----- rtl/bitmap_blit_to_led_frame.sv -----
// bitmap blit top level: configuration registers, cursor unit and pixel emitter
// depends on bbl_pkg, bbl_cursor, bbl_emit
`timescale 1ns / 1ps

// Turns a stream of bitmap bytes into frame-buffer writes for a 16 x 18 LED
// panel. In 1-bit mode each byte gives min(8, pixels left in the row) pixel
// items, MSB first, zero bits in the foreground colour; in 8-bit mode a byte
// is one pixel. Each pixel item leaves the rsp channel as a separate transfer
// through the emitter's single output register, held there while rsp_stall is
// high. A byte that gives no pixels (finished or empty image) is absorbed
// with no pixel item. The first pixel of a byte passes through the work
// register and then the output register, and the next byte is taken while
// the current one is still being emitted. Clipped pixels still come out,
// with in_panel low and zero data; the last flag marks each byte's final
// pixel. The user must write configuration registers only while the block is
// idle, which the block does not enforce; the csr port never stalls.

module bitmap_blit_to_led_frame (
   input  logic             clock,
   input  logic             reset,
   // bitmap byte input
   input  logic             req_valid,
   output logic             req_stall,
   input  bbl_pkg::req_type req_data,
   // pixel write output
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bbl_pkg::rsp_type rsp_data,
   // register write port
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_data
);
   import bbl_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   plan_type plan;
   logic     busy;
   logic     accept;

   // register file, writes to unused indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEPTH_MODE:   cfg_in.depth_mode   = csr_data[0];
            CSR_ORIGIN_X:     cfg_in.origin_x     = csr_data;
            CSR_ORIGIN_Y:     cfg_in.origin_y     = csr_data;
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_data;
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_data;
            CSR_FORE_COLOUR:  cfg_in.fore_colour  = csr_data;
            CSR_BACK_COLOUR:  cfg_in.back_colour  = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // a byte is taken whenever the emitter can load a new run next cycle
   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   bbl_cursor u_cursor (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_data),
      .cfg   (cfg_ff),
      .plan  (plan)
   );

   bbl_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .plan     (plan),
      .cfg      (cfg_ff),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

// ----- rtl/bbl_cursor.sv -----
// bitmap blit cursor unit: tracks the bitmap cursor and plans each byte's pixel run
// depends on bbl_pkg
`timescale 1ns / 1ps

module bbl_cursor (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  bbl_pkg::req_type req,
   input  bbl_pkg::cfg_type cfg,
   output bbl_pkg::plan_type plan
);
   import bbl_pkg::*;

   logic [7:0] cursor_col_ff, cursor_col_in;
   logic [7:0] cursor_row_ff, cursor_row_in;
   logic       image_done_ff, image_done_in;

   logic [7:0] col0, row0, col1, row1, row_wrap, rem, row_next;
   logic       done0, wrap, wrap_done, empty;
   logic [3:0] count;
   logic [8:0] col_end;

   always_comb begin
      // first byte restarts at the top left
      col0  = req.first_byte ? 8'd0 : cursor_col_ff;
      row0  = req.first_byte ? 8'd0 : cursor_row_ff;
      done0 = req.first_byte ? 1'b0 : image_done_ff;

      empty = done0 || (cfg.image_width == 8'd0) || (cfg.image_height == 8'd0)
              || (row0 >= cfg.image_height);

      // shrunk width: move to the next row first
      wrap      = col0 >= cfg.image_width;
      row_wrap  = row0 + 8'd1;
      wrap_done = wrap && (row_wrap >= cfg.image_height);
      col1      = wrap ? 8'd0 : col0;
      row1      = wrap ? row_wrap : row0;

      rem = cfg.image_width - col1;
      if (cfg.depth_mode) begin
         count = 4'd1;
      end else if (rem >= 8'(MaxPix)) begin
         count = 4'(MaxPix);
      end else begin
         count = rem[3:0];
      end

      col_end  = {1'b0, col1} + {5'd0, count};
      row_next = row1 + 8'd1;

      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      image_done_in = image_done_ff;
      plan.valid      = 1'b0;
      plan.depth_mode = cfg.depth_mode;
      plan.col        = col1;
      plan.row        = row1;
      plan.bits       = req.bitmap_byte;
      plan.count      = count;

      if (accept) begin
         if (empty) begin
            cursor_col_in = col0;
            cursor_row_in = row0;
            image_done_in = 1'b1;
         end else if (wrap_done) begin
            cursor_col_in = 8'd0;
            cursor_row_in = row_wrap;
            image_done_in = 1'b1;
         end else begin
            plan.valid = 1'b1;
            if (col_end == {1'b0, cfg.image_width}) begin
               cursor_col_in = 8'd0;
               cursor_row_in = row_next;
               image_done_in = row_next >= cfg.image_height;
            end else begin
               cursor_col_in = col_end[7:0];
               cursor_row_in = row1;
               image_done_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= 8'd0;
         cursor_row_ff <= 8'd0;
         image_done_ff <= 1'b0;
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         image_done_ff <= image_done_in;
      end
   end

endmodule

// ----- rtl/bbl_emit.sv -----
// bitmap blit emitter: steps through a planned pixel run, clips and remaps each pixel
// depends on bbl_pkg
`timescale 1ns / 1ps

module bbl_emit (
   input  logic              clock,
   input  logic              reset,
   input  bbl_pkg::plan_type plan,
   input  bbl_pkg::cfg_type  cfg,
   output logic              busy,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bbl_pkg::rsp_type  rsp_data
);
   import bbl_pkg::*;

   plan_type   work_ff, work_in;
   logic       work_valid_ff, work_valid_in;
   logic [2:0] bit_ff, bit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       adv, final_px, on_panel, px_bit;
   logic [7:0] col, sx, sy, value;
   logic [3:0] mx;
   logic [4:0] my;

   always_comb begin
      adv      = work_valid_ff && (!rsp_valid_ff || !rsp_stall);
      final_px = adv && ({1'b0, bit_ff} == (work_ff.count - 4'd1));
      busy     = work_valid_ff && !final_px;

      col    = work_ff.col + {5'd0, bit_ff};
      sx     = cfg.origin_x + col;
      sy     = cfg.origin_y + work_ff.row;
      px_bit = work_ff.bits[3'd7 - bit_ff];
      if (work_ff.depth_mode) begin
         value = work_ff.bits;
      end else begin
         value = px_bit ? cfg.back_colour : cfg.fore_colour;
      end

      on_panel = (sx < 8'(PanelW)) && (sy < 8'(PanelH));
      // mirror both axes; if mirrored column >= 8, flip it and each 9-row half back
      mx = MirrorX - sx[3:0];
      my = MirrorY - sy[4:0];
      if (mx[3]) begin
         mx = 4'(FoldX - {1'b0, mx});
         my = (my <= FoldYLo) ? (FoldYLo - my) : (FoldYHi - my);
      end

      rsp_in.last = final_px;
      if (on_panel) begin
         rsp_in.fb_index    = {my, mx};
         rsp_in.pixel_value = value;
         rsp_in.in_panel    = 1'b1;
      end else begin
         rsp_in.fb_index    = 9'd0;
         rsp_in.pixel_value = 8'd0;
         rsp_in.in_panel    = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      bit_in        = bit_ff;
      if (plan.valid) begin
         work_in       = plan;
         work_valid_in = 1'b1;
         bit_in        = 3'd0;
      end else if (final_px) begin
         work_valid_in = 1'b0;
      end else if (adv) begin
         bit_in = bit_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         bit_ff        <= 3'd0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         bit_ff        <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_bit_in_run: assert property (@(posedge clock) disable iff (reset)
      work_valid_ff |-> ({1'b0, bit_ff} < work_ff.count))
      else $error("pixel counter past end of run");
   a_clipped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.in_panel) |->
      (rsp_ff.fb_index == 9'd0 && rsp_ff.pixel_value == 8'd0))
      else $error("clipped pixel carries data");
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.in_panel) |-> (rsp_ff.fb_index < 9'(FbDepth)))
      else $error("frame buffer index out of range");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (plan.valid && work_valid_ff) |-> final_px)
      else $error("new run loaded over unfinished run");
`endif

endmodule
